[src/trade_price_volume_anomaly_detector_unit_macros.svh]
// Assertion macros shared by the checker of the anomaly detector.
`ifndef TRADE_PRICE_VOLUME_ANOMALY_DETECTOR_UNIT_MACROS_SVH
`define TRADE_PRICE_VOLUME_ANOMALY_DETECTOR_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define TPVAD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TPVAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/tpvad_pkg.sv]
// Shared types and constants of the trade anomaly detector.
package tpvad_pkg;

  localparam int PRICE_W     = 40;
  localparam int QTY_W       = 40;
  localparam int TIME_W      = 63;
  localparam int SEV_W       = 17;
  localparam int FRAC_W      = 16;
  localparam int KIND_W      = 2;
  localparam int COUNT_W     = 32;
  localparam int CFG_W       = 16;
  localparam int LEN_W       = 9;
  localparam int CFG_IDX_W   = 3;

  localparam int WINDOW_DEPTH_DEF = 256;
  localparam int SAMPLE_BITS_DEF  = 40;

  localparam int PRICE_MIN_FILL  = 2;
  localparam int VOLUME_MIN_FILL = 10;

  localparam logic [CFG_W-1:0] PRICE_LIMIT_RST = 16'd3277;
  localparam logic [CFG_W-1:0] VOLUME_MULT_RST = 16'd768;
  localparam logic [CFG_W-1:0] VOLUME_DROP_RST = 16'd6554;
  localparam logic [LEN_W-1:0] WINDOW_LEN_RST  = 9'd100;

  localparam logic [SEV_W-1:0] SEV_ONE = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRICE_LIMIT = 3'd0,
    CFG_VOLUME_MULT = 3'd1,
    CFG_VOLUME_DROP = 3'd2,
    CFG_PRICE_LEN   = 3'd3,
    CFG_VOLUME_LEN  = 3'd4
  } cfg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    VK_NONE  = 2'd0,
    VK_SPIKE = 2'd1,
    VK_DROP  = 2'd2
  } vol_kind_t;

  typedef struct packed {
    logic load;
    logic start_sev;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

endpackage

[src/tpvad_div.sv]
// Restoring divider that retires one quotient bit per cycle.
module tpvad_div #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 67
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [$clog2(NUM_W+1)-1:0]    steps,
  input  logic [DEN_W-1:0]              init_rem,
  input  logic [NUM_W-1:0]              dividend,
  input  logic [DEN_W-1:0]              den,
  output logic [NUM_W-1:0]              quo,
  output logic                          done
);
  localparam int CNT_W = $clog2(NUM_W+1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] dq_r;
  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;
  logic [NUM_W-1:0] dq_nxt;

  always_comb begin
    trial   = {rem_r, dq_r[NUM_W-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
    dq_nxt  = {dq_r[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= init_rem;
      dq_r  <= dividend;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
    end
  end

  assign quo  = dq_r;
  assign done = done_r;

endmodule

[src/tpvad_win.sv]
// Sliding window of samples kept in a ring memory with a running total.
module tpvad_win #(
  parameter int DEPTH  = 256,
  parameter int SW     = 40,
  parameter int FILL_W = 9,
  parameter int TOT_W  = 49
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [tpvad_pkg::LEN_W-1:0]  len,
  input  logic                         load,
  input  logic                         push,
  input  logic [SW-1:0]                sample,
  output logic [TOT_W-1:0]             total,
  output logic [FILL_W-1:0]            fill
);
  import tpvad_pkg::*;

  localparam int ADDR_W = $clog2(DEPTH);

  logic [SW-1:0]     ring [DEPTH];
  logic [SW-1:0]     old_r;
  logic [ADDR_W-1:0] head_r;
  logic [ADDR_W-1:0] head_nxt;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [TOT_W-1:0]  total_r;
  logic [TOT_W-1:0]  total_nxt;
  logic [31:0]       len32;
  logic [31:0]       clen32;
  logic              full;
  logic [FILL_W:0]   sum;
  logic [ADDR_W-1:0] wr_addr;

  always_comb begin
    len32 = 32'(len);
    if (len32 == 32'd0) begin
      clen32 = 32'd1;
    end else if (len32 > 32'(DEPTH)) begin
      clen32 = 32'(DEPTH);
    end else begin
      clen32 = len32;
    end
    full    = 32'(fill_r) >= clen32;
    sum     = (FILL_W+1)'(head_r) + (FILL_W+1)'(fill_r);
    wr_addr = (sum >= (FILL_W+1)'(DEPTH)) ? ADDR_W'(sum - (FILL_W+1)'(DEPTH))
                                          : ADDR_W'(sum);
    head_nxt = head_r;
    fill_nxt = fill_r + 1'b1;
    total_nxt = total_r + TOT_W'(sample);
    if (full) begin
      head_nxt  = (head_r == ADDR_W'(DEPTH-1)) ? '0 : head_r + 1'b1;
      fill_nxt  = fill_r;
      total_nxt = total_r - TOT_W'(old_r) + TOT_W'(sample);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      fill_r  <= '0;
      total_r <= '0;
    end else if (push) begin
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ring[wr_addr] <= sample;
    end
    if (load) begin
      old_r <= ring[head_r];
    end
  end

  assign total = total_r;
  assign fill  = fill_r;

endmodule

[src/tpvad_dp.sv]
// Datapath: configuration, windows, threshold arithmetic, dividers and result registers.
module tpvad_dp #(
  parameter int WINDOW_DEPTH = tpvad_pkg::WINDOW_DEPTH_DEF,
  parameter int SAMPLE_BITS  = tpvad_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [tpvad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpvad_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic [tpvad_pkg::PRICE_W-1:0]    in_trade_price,
  input  logic [tpvad_pkg::QTY_W-1:0]      in_trade_qty,
  input  logic [tpvad_pkg::TIME_W-1:0]     in_event_time,
  input  tpvad_pkg::dp_cmd_t               cmd,
  output tpvad_pkg::dp_stat_t              stat,
  output logic                             out_price_spike,
  output logic [tpvad_pkg::SEV_W-1:0]      out_price_severity,
  output logic [tpvad_pkg::PRICE_W-1:0]    out_price_mean,
  output logic [tpvad_pkg::KIND_W-1:0]     out_volume_kind,
  output logic [tpvad_pkg::SEV_W-1:0]      out_volume_severity,
  output logic [tpvad_pkg::QTY_W-1:0]      out_volume_mean,
  output logic [tpvad_pkg::TIME_W-1:0]     out_stamp,
  output logic [tpvad_pkg::COUNT_W-1:0]    out_anomaly_total
);
  import tpvad_pkg::*;

  localparam int SW     = SAMPLE_BITS;
  localparam int FILL_W = $clog2(WINDOW_DEPTH+1);
  localparam int TOT_W  = SW + FILL_W;
  localparam int DEN_W  = TOT_W + 18;
  localparam int STEP_W = $clog2(TOT_W+1);

  logic [CFG_W-1:0]   plimit_r, vmult_r, vdrop_r;
  logic [LEN_W-1:0]   plen_r, vlen_r;
  logic [SW-1:0]      p_r, q_r;
  logic [TIME_W-1:0]  time_r;
  logic [TOT_W-1:0]   ptot, vtot;
  logic [FILL_W-1:0]  pfill, vfill;

  logic [TOT_W-1:0]    pf_r, qf_r, pdev_r;
  logic [TOT_W+15:0]   pthr_r, vthr_r, b_r;
  logic [DEN_W-1:0]    pden_r;
  logic [TOT_W+16:0]   vden_r;
  logic [17:0]         plimit3;
  logic [16:0]         vmult2;

  logic [TOT_W+15:0]   lhs, a_val, bma;
  logic [TOT_W+7:0]    up;
  logic                pok, vok, pflag, vspk, vdrp, psat, vsat;
  vol_kind_t           kind;

  logic [STEP_W-1:0]   steps;
  logic [DEN_W-1:0]    p_init, p_den, v_init, v_den;
  logic [TOT_W-1:0]    p_dvd, v_dvd, pquo, vquo;
  logic                pdone, vdone;

  logic                pflag_r, psat_r, vsat_r;
  vol_kind_t           kind_r;
  logic [PRICE_W-1:0]  pavg_r;
  logic [QTY_W-1:0]    vavg_r;

  logic                o_pspike_r;
  logic [SEV_W-1:0]    o_psev_r, o_vsev_r;
  logic [PRICE_W-1:0]  o_pavg_r;
  logic [QTY_W-1:0]    o_vavg_r;
  logic [KIND_W-1:0]   o_vkind_r;
  logic [TIME_W-1:0]   o_stamp_r;
  logic [COUNT_W-1:0]  cnt_r;
  logic [COUNT_W:0]    cnt_sum;
  logic [SEV_W-1:0]    psev_nxt, vsev_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plimit_r <= PRICE_LIMIT_RST;
      vmult_r  <= VOLUME_MULT_RST;
      vdrop_r  <= VOLUME_DROP_RST;
      plen_r   <= WINDOW_LEN_RST;
      vlen_r   <= WINDOW_LEN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PRICE_LIMIT: plimit_r <= cfg_wdata;
        CFG_VOLUME_MULT: vmult_r  <= cfg_wdata;
        CFG_VOLUME_DROP: vdrop_r  <= cfg_wdata;
        CFG_PRICE_LEN:   plen_r   <= LEN_W'(cfg_wdata);
        CFG_VOLUME_LEN:  vlen_r   <= LEN_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_r    <= SW'(in_trade_price);
      q_r    <= SW'(in_trade_qty);
      time_r <= in_event_time;
    end
  end

  tpvad_win #(
    .DEPTH(WINDOW_DEPTH), .SW(SW), .FILL_W(FILL_W), .TOT_W(TOT_W)
  ) u_pwin (
    .clk(clk), .rst_n(rst_n), .len(plen_r), .load(cmd.load), .push(cmd.commit),
    .sample(p_r), .total(ptot), .fill(pfill)
  );

  tpvad_win #(
    .DEPTH(WINDOW_DEPTH), .SW(SW), .FILL_W(FILL_W), .TOT_W(TOT_W)
  ) u_vwin (
    .clk(clk), .rst_n(rst_n), .len(vlen_r), .load(cmd.load), .push(cmd.commit),
    .sample(q_r), .total(vtot), .fill(vfill)
  );

  assign plimit3 = 18'(plimit_r) + {1'b0, plimit_r, 1'b0};
  assign vmult2  = {vmult_r, 1'b0};

  // Operand registers settle while the average division runs, before the compare.
  always_ff @(posedge clk) begin
    pf_r   <= TOT_W'(p_r) * TOT_W'(pfill);
    qf_r   <= TOT_W'(q_r) * TOT_W'(vfill);
    pthr_r <= (TOT_W+16)'(plimit_r) * (TOT_W+16)'(ptot);
    pden_r <= DEN_W'(plimit3) * DEN_W'(ptot);
    vthr_r <= (TOT_W+16)'(vmult_r) * (TOT_W+16)'(vtot);
    vden_r <= (TOT_W+17)'(vmult2) * (TOT_W+17)'(vtot);
    b_r    <= (TOT_W+16)'(vdrop_r) * (TOT_W+16)'(vtot);
    pdev_r <= (pf_r >= ptot) ? pf_r - ptot : ptot - pf_r;
  end

  always_comb begin
    lhs   = {pdev_r, 16'b0};
    up    = {qf_r, 8'b0};
    a_val = {qf_r, 16'b0};
    bma   = b_r - a_val;
    pok   = (32'(pfill) >= 32'(PRICE_MIN_FILL)) && (ptot != '0);
    vok   = (32'(vfill) >= 32'(VOLUME_MIN_FILL)) && (vtot != '0);
    pflag = pok && (lhs > pthr_r);
    vspk  = (TOT_W+16)'(up) > vthr_r;
    vdrp  = a_val < b_r;
    psat  = DEN_W'(lhs) >= pden_r;
    if (!vok) begin
      kind = VK_NONE;
    end else if (vspk) begin
      kind = VK_SPIKE;
    end else if (vdrp) begin
      kind = VK_DROP;
    end else begin
      kind = VK_NONE;
    end
    vsat = vspk ? ((TOT_W+17)'(up) >= vden_r) : (qf_r == '0);
  end

  always_comb begin
    if (cmd.load) begin
      steps  = STEP_W'(TOT_W);
      p_init = '0;
      p_dvd  = ptot;
      p_den  = DEN_W'(pfill);
      v_init = '0;
      v_dvd  = vtot;
      v_den  = DEN_W'(vfill);
    end else begin
      steps  = STEP_W'(FRAC_W);
      p_init = DEN_W'(lhs);
      p_dvd  = '0;
      p_den  = pden_r;
      v_dvd  = '0;
      if (vspk) begin
        v_init = DEN_W'(up);
        v_den  = DEN_W'(vden_r);
      end else begin
        v_init = DEN_W'(bma);
        v_den  = DEN_W'(b_r);
      end
    end
  end

  tpvad_div #(.NUM_W(TOT_W), .DEN_W(DEN_W)) u_pdiv (
    .clk(clk), .rst_n(rst_n), .start(cmd.load | cmd.start_sev), .steps(steps),
    .init_rem(p_init), .dividend(p_dvd), .den(p_den), .quo(pquo), .done(pdone)
  );

  tpvad_div #(.NUM_W(TOT_W), .DEN_W(DEN_W)) u_vdiv (
    .clk(clk), .rst_n(rst_n), .start(cmd.load | cmd.start_sev), .steps(steps),
    .init_rem(v_init), .dividend(v_dvd), .den(v_den), .quo(vquo), .done(vdone)
  );

  assign stat.div_done = pdone & vdone;

  always_ff @(posedge clk) begin
    if (cmd.start_sev) begin
      pflag_r <= pflag;
      psat_r  <= psat;
      kind_r  <= kind;
      vsat_r  <= vsat;
      pavg_r  <= (pfill == '0) ? '0 : PRICE_W'(pquo);
      vavg_r  <= (vfill == '0) ? '0 : QTY_W'(vquo);
    end
  end

  always_comb begin
    psev_nxt = '0;
    if (pflag_r) begin
      psev_nxt = psat_r ? SEV_ONE : {1'b0, pquo[FRAC_W-1:0]};
    end
    vsev_nxt = '0;
    if (kind_r != VK_NONE) begin
      vsev_nxt = vsat_r ? SEV_ONE : {1'b0, vquo[FRAC_W-1:0]};
    end
    cnt_sum = (COUNT_W+1)'(cnt_r) + (COUNT_W+1)'(pflag_r)
              + (COUNT_W+1)'(kind_r != VK_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.commit) begin
      cnt_r <= cnt_sum[COUNT_W] ? '1 : cnt_sum[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      o_pspike_r <= pflag_r;
      o_psev_r   <= psev_nxt;
      o_pavg_r   <= pavg_r;
      o_vkind_r  <= kind_r;
      o_vsev_r   <= vsev_nxt;
      o_vavg_r   <= vavg_r;
      o_stamp_r  <= time_r;
    end
  end

  assign out_price_spike     = o_pspike_r;
  assign out_price_severity  = o_psev_r;
  assign out_price_mean      = o_pavg_r;
  assign out_volume_kind     = o_vkind_r;
  assign out_volume_severity = o_vsev_r;
  assign out_volume_mean     = o_vavg_r;
  assign out_stamp           = o_stamp_r;
  assign out_anomaly_total   = cnt_r;

endmodule

[src/tpvad_ctrl.sv]
// Controller that sequences one trade through the datapath.
module tpvad_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tpvad_pkg::dp_cmd_t   cmd,
  input  tpvad_pkg::dp_stat_t  stat
);
  import tpvad_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AVG,
    S_CMP,
    S_SEV,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_AVG;
        end
      end
      S_AVG: begin
        if (stat.div_done) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.start_sev = 1'b1;
        state_nxt     = S_SEV;
      end
      S_SEV: begin
        if (stat.div_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[src/trade_price_volume_anomaly_detector_unit.sv]
// Trades are handled one at a time: in_ready is high only while idle, and a new trade is taken
// only after the current result has been committed. The bit-serial average division takes
// TOT_W = SAMPLE_BITS + clog2(WINDOW_DEPTH + 1) steps. A finished result waits in the output
// register while the next trade is taken.
// Reset is synchronous and active low; it empties both windows, zeroes the count and
// restores the register defaults. Ring memories are not cleared.
module trade_price_volume_anomaly_detector_unit #(
  parameter int WINDOW_DEPTH = tpvad_pkg::WINDOW_DEPTH_DEF,
  parameter int SAMPLE_BITS  = tpvad_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [tpvad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpvad_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tpvad_pkg::PRICE_W-1:0]    in_trade_price,
  input  logic [tpvad_pkg::QTY_W-1:0]      in_trade_qty,
  input  logic [tpvad_pkg::TIME_W-1:0]     in_event_time,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_price_spike,
  output logic [tpvad_pkg::SEV_W-1:0]      out_price_severity,
  output logic [tpvad_pkg::PRICE_W-1:0]    out_price_mean,
  output logic [tpvad_pkg::KIND_W-1:0]     out_volume_kind,
  output logic [tpvad_pkg::SEV_W-1:0]      out_volume_severity,
  output logic [tpvad_pkg::QTY_W-1:0]      out_volume_mean,
  output logic [tpvad_pkg::TIME_W-1:0]     out_stamp,
  output logic [tpvad_pkg::COUNT_W-1:0]    out_anomaly_total
);
  import tpvad_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tpvad_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .stat(stat)
  );

  tpvad_dp #(.WINDOW_DEPTH(WINDOW_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_trade_price(in_trade_price), .in_trade_qty(in_trade_qty),
    .in_event_time(in_event_time), .cmd(cmd), .stat(stat),
    .out_price_spike(out_price_spike), .out_price_severity(out_price_severity),
    .out_price_mean(out_price_mean), .out_volume_kind(out_volume_kind),
    .out_volume_severity(out_volume_severity), .out_volume_mean(out_volume_mean),
    .out_stamp(out_stamp), .out_anomaly_total(out_anomaly_total)
  );

endmodule

[src/tpvad_checker.sv]
// Port-level checker of the anomaly detector and its bind statement.
`include "trade_price_volume_anomaly_detector_unit_macros.svh"

module tpvad_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             cfg_wr_en,
  input logic [tpvad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [tpvad_pkg::CFG_W-1:0]      cfg_wdata,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic [tpvad_pkg::PRICE_W-1:0]    in_trade_price,
  input logic [tpvad_pkg::QTY_W-1:0]      in_trade_qty,
  input logic [tpvad_pkg::TIME_W-1:0]     in_event_time,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_price_spike,
  input logic [tpvad_pkg::SEV_W-1:0]      out_price_severity,
  input logic [tpvad_pkg::PRICE_W-1:0]    out_price_mean,
  input logic [tpvad_pkg::KIND_W-1:0]     out_volume_kind,
  input logic [tpvad_pkg::SEV_W-1:0]      out_volume_severity,
  input logic [tpvad_pkg::QTY_W-1:0]      out_volume_mean,
  input logic [tpvad_pkg::TIME_W-1:0]     out_stamp,
  input logic [tpvad_pkg::COUNT_W-1:0]    out_anomaly_total
);
  import tpvad_pkg::*;

  `TPVAD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped before transfer")
  `TPVAD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_stamp) && $stable(out_anomaly_total), "stalled result changed")
  `TPVAD_ASSERT_SAME(a_psev, out_valid, (out_price_spike || out_price_severity == '0) && out_price_severity <= SEV_ONE, "price severity inconsistent with flag")
  `TPVAD_ASSERT_SAME(a_vsev, out_valid && out_volume_kind == VK_NONE, out_volume_severity == '0, "volume severity without anomaly")

endmodule

bind trade_price_volume_anomaly_detector_unit tpvad_checker u_tpvad_checker (.*);
